// ===== src/mexp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the modular exponentiation unit.
// No dependencies; every other file refers to this package by scoped names.
package mexp_pkg;

    // Field widths
    localparam int DATA_WIDTH = 32;
    localparam int MOD_WIDTH  = 32;
    localparam int EXP_WIDTH  = 32;
    localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [MOD_WIDTH-1:0]  mod_t;
    typedef logic [MOD_WIDTH+1:0]  sum_t;
    typedef logic [EXP_WIDTH-1:0]  exp_t;
    typedef logic [CNT_WIDTH-1:0]  cnt_t;

    // Which product the shared multiplier forms
    typedef enum logic [1:0] {
        MUL_REDUCE,
        MUL_ACC,
        MUL_SQUARE
    } mul_sel_t;

    // Source of the result word
    typedef enum logic [1:0] {
        RES_ZERO,
        RES_ONE,
        RES_ACC
    } res_sel_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_BIT,
        ST_FINISH
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     load;
        logic     start;
        logic     step;
        mul_sel_t sel;
        mul_sel_t start_sel;
        logic     out_load;
        res_sel_t res;
    } mexp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic mod_small;
        logic exp_zero;
        logic exp_bit;
        logic mul_last;
    } mexp_stat_t;

endpackage

// ===== src/mexp_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for operand and result words.
// Depends on mexp_pkg for the field widths.
interface mexp_in_if;
    logic                  valid;
    logic                  ready;
    mexp_pkg::data_t       base;
    mexp_pkg::data_t       exponent;
    mexp_pkg::data_t       modulus;

    modport source (output valid, output base, output exponent, output modulus, input ready);
    modport sink   (input valid, input base, input exponent, input modulus, output ready);
endinterface

interface mexp_out_if;
    logic                  valid;
    logic                  ready;
    mexp_pkg::data_t       power;

    modport source (output valid, output power, input ready);
    modport sink   (input valid, input power, output ready);
endinterface

// ===== src/mexp_dp.sv =====
`timescale 1ns / 1ps
// Datapath: operand registers, bit-serial modular multiplier and result register.
// Depends on mexp_pkg; driven by commands from mexp_ctrl.
module mexp_dp (
    input  logic                  clk,
    input  mexp_pkg::data_t       base,
    input  mexp_pkg::data_t       exponent,
    input  mexp_pkg::data_t       modulus,
    input  mexp_pkg::mexp_cmd_t   cmd,
    output mexp_pkg::mexp_stat_t  stat,
    output mexp_pkg::data_t       power
);

    mexp_pkg::data_t base_reg;
    mexp_pkg::exp_t  exp_reg;
    mexp_pkg::mod_t  mod_reg;
    mexp_pkg::mod_t  acc_reg;
    mexp_pkg::mod_t  pw_reg;
    mexp_pkg::data_t x_reg;
    mexp_pkg::mod_t  y_reg;
    mexp_pkg::mod_t  r_reg;
    mexp_pkg::cnt_t  cnt_reg;
    mexp_pkg::data_t power_reg;

    mexp_pkg::sum_t  t_sum;
    mexp_pkg::sum_t  m_one;
    mexp_pkg::sum_t  m_two;
    mexp_pkg::sum_t  t_red;
    mexp_pkg::mod_t  r_next;
    mexp_pkg::data_t x_start;
    mexp_pkg::mod_t  y_start;

    // One multiplier step: r = (2r + xbit*y) mod m, with r, y below m
    always_comb
    begin
        m_one = mexp_pkg::sum_t'(mod_reg);
        m_two = m_one << 1;
        t_sum = (mexp_pkg::sum_t'(r_reg) << 1)
              + (x_reg[mexp_pkg::DATA_WIDTH-1] ? mexp_pkg::sum_t'(y_reg) : '0);
        if (t_sum >= m_two)
        begin
            t_red = t_sum - m_two;
        end
        else if (t_sum >= m_one)
        begin
            t_red = t_sum - m_one;
        end
        else
        begin
            t_red = t_sum;
        end
        r_next = mexp_pkg::mod_t'(t_red);
    end

    // Pick multiplier operands for the next product
    always_comb
    begin
        case (cmd.start_sel)
            mexp_pkg::MUL_REDUCE:
            begin
                x_start = base_reg;
                y_start = mexp_pkg::mod_t'(1);
            end
            mexp_pkg::MUL_ACC:
            begin
                x_start = mexp_pkg::data_t'(acc_reg);
                y_start = pw_reg;
            end
            mexp_pkg::MUL_SQUARE:
            begin
                x_start = mexp_pkg::data_t'(pw_reg);
                y_start = pw_reg;
            end
            default:
            begin
                x_start = '0;
                y_start = '0;
            end
        endcase
    end

    // Capture operands, run the multiplier and write back products
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg <= base;
            exp_reg  <= mexp_pkg::exp_t'(exponent);
            mod_reg  <= mexp_pkg::mod_t'(modulus);
            acc_reg  <= mexp_pkg::mod_t'(1);
        end

        if (cmd.step && stat.mul_last)
        begin
            case (cmd.sel)
                mexp_pkg::MUL_REDUCE: pw_reg <= r_next;
                mexp_pkg::MUL_ACC:    acc_reg <= r_next;
                mexp_pkg::MUL_SQUARE:
                begin
                    pw_reg  <= r_next;
                    exp_reg <= exp_reg >> 1;
                end
                default: ;
            endcase
        end

        if (cmd.start)
        begin
            x_reg   <= x_start;
            y_reg   <= y_start;
            r_reg   <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.step)
        begin
            x_reg   <= x_reg << 1;
            r_reg   <= r_next;
            cnt_reg <= cnt_reg + mexp_pkg::cnt_t'(1);
        end

        // Hold the finished word for the output channel
        if (cmd.out_load)
        begin
            case (cmd.res)
                mexp_pkg::RES_ZERO: power_reg <= '0;
                mexp_pkg::RES_ONE:  power_reg <= mexp_pkg::data_t'(1);
                mexp_pkg::RES_ACC:  power_reg <= mexp_pkg::data_t'(acc_reg);
                default:            power_reg <= '0;
            endcase
        end
    end

    assign stat.mod_small = (mod_reg < mexp_pkg::mod_t'(2));
    assign stat.exp_zero  = (exp_reg == '0);
    assign stat.exp_bit   = exp_reg[0];
    assign stat.mul_last  = (cnt_reg == mexp_pkg::cnt_t'(mexp_pkg::DATA_WIDTH - 1));
    assign power          = power_reg;

endmodule

// ===== src/mexp_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences reduction and square-and-multiply over the exponent bits.
// Depends on mexp_pkg; commands mexp_dp and owns the channel handshakes.
module mexp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  mexp_pkg::mexp_stat_t  stat,
    output mexp_pkg::mexp_cmd_t   cmd
);

    mexp_pkg::state_t   state_reg;
    mexp_pkg::state_t   state_next;
    mexp_pkg::mul_sel_t sel_reg;
    mexp_pkg::mul_sel_t sel_next;
    mexp_pkg::res_sel_t res_reg;
    mexp_pkg::res_sel_t res_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mexp_pkg::ST_IDLE;
            sel_reg       <= mexp_pkg::MUL_REDUCE;
            res_reg       <= mexp_pkg::RES_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        sel_next      = sel_reg;
        res_next      = res_reg;
        in_ready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.start     = 1'b0;
        cmd.step      = 1'b0;
        cmd.sel       = sel_reg;
        cmd.start_sel = sel_reg;
        cmd.out_load  = 1'b0;
        cmd.res       = res_reg;

        case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = mexp_pkg::ST_CHECK;
                end
            end
            mexp_pkg::ST_CHECK:
            begin
                if (stat.mod_small)
                begin
                    res_next   = mexp_pkg::RES_ZERO;
                    state_next = mexp_pkg::ST_FINISH;
                end
                else if (stat.exp_zero)
                begin
                    res_next   = mexp_pkg::RES_ONE;
                    state_next = mexp_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.start     = 1'b1;
                    cmd.start_sel = mexp_pkg::MUL_REDUCE;
                    sel_next      = mexp_pkg::MUL_REDUCE;
                    state_next    = mexp_pkg::ST_MUL;
                end
            end
            mexp_pkg::ST_MUL:
            begin
                cmd.step = 1'b1;
                if (stat.mul_last)
                begin
                    // chain the square after a multiply into the accumulator
                    if (sel_reg == mexp_pkg::MUL_ACC)
                    begin
                        cmd.start     = 1'b1;
                        cmd.start_sel = mexp_pkg::MUL_SQUARE;
                        sel_next      = mexp_pkg::MUL_SQUARE;
                    end
                    else
                    begin
                        state_next = mexp_pkg::ST_BIT;
                    end
                end
            end
            mexp_pkg::ST_BIT:
            begin
                if (stat.exp_zero)
                begin
                    res_next   = mexp_pkg::RES_ACC;
                    state_next = mexp_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.start     = 1'b1;
                    cmd.start_sel = stat.exp_bit ? mexp_pkg::MUL_ACC : mexp_pkg::MUL_SQUARE;
                    sel_next      = cmd.start_sel;
                    state_next    = mexp_pkg::ST_MUL;
                end
            end
            mexp_pkg::ST_FINISH:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = mexp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mexp_pkg::ST_IDLE;
            end
        endcase

        out_valid_next = cmd.out_load | (out_valid_reg & ~out_ready);
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== src/modular_exponentiation_unit.sv =====
`timescale 1ns / 1ps
// Modular exponentiation unit: power = base ** exponent mod modulus.
// Usage:
//   operands channel (sink): one word carries base, exponent and modulus; it is
//   taken when valid and ready are both high. ready is high while the unit is
//   free, including while a finished result still waits on the result channel.
//   result channel (source): one word per operand word, field power.
//   A modulus of 0 or 1 gives 0; an exponent of 0 gives 1 otherwise.
// Timing:
//   The base is first reduced by the shared bit-serial multiplier, then each
//   exponent bit costs a decision state, a square and, for a set bit, a
//   multiply, so the time to a result grows with the bit length of the exponent
//   and its count of set bits. Special cases skip the multiplier.
//   One item is worked on at a time; the multiplier sets the rate.
// Reset:
//   rst_n is asynchronous and active low; it empties the unit and drops valid.
// Stalls:
//   The result word holds until taken; a second result waits in the unit
//   until the result register frees up.
// Depends on mexp_pkg, mexp_if, mexp_ctrl and mexp_dp.
module modular_exponentiation_unit (
    input  logic       clk,
    input  logic       rst_n,
    mexp_in_if.sink    operands,
    mexp_out_if.source result
);

    mexp_pkg::mexp_cmd_t  cmd;
    mexp_pkg::mexp_stat_t stat;

    mexp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (operands.valid),
        .in_ready  (operands.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mexp_dp u_dp (
        .clk      (clk),
        .base     (operands.base),
        .exponent (operands.exponent),
        .modulus  (operands.modulus),
        .cmd      (cmd),
        .stat     (stat),
        .power    (result.power)
    );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for modular_exponentiation_unit: drives operand words, checks every result word against
// a table value or a square-and-multiply predictor. Depends on mexp_pkg, mexp_if and the unit.
module tb_top;

    localparam int    RANDOM_ITEMS = 266;
    localparam int    TAIL_CYCLES  = 2200;
    localparam int    CYCLE_LIMIT  = 4000000;
    localparam int    DIR_ROWS     = 24;
    localparam logic [63:0] EXP_MASK =
        (mexp_pkg::EXP_WIDTH >= 64) ? {64{1'b1}} :
        ((64'd1 << mexp_pkg::EXP_WIDTH) - 64'd1);
    localparam logic [63:0] MOD_MASK =
        (mexp_pkg::MOD_WIDTH >= 64) ? {64{1'b1}} :
        ((64'd1 << mexp_pkg::MOD_WIDTH) - 64'd1);

    // One directed row; power is only used where known is set
    typedef struct packed {
        mexp_pkg::data_t base;
        mexp_pkg::data_t exponent;
        mexp_pkg::data_t modulus;
        logic            known;
        mexp_pkg::data_t power;
    } dir_row_t;

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{32'd5,         32'd3,         32'd0,         1'b1, 32'd0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,         1'b1, 32'd0},
        '{32'd7,         32'd9,         32'd1,         1'b1, 32'd0},
        '{32'd12345,     32'd0,         32'd2,         1'b1, 32'd1},
        '{32'hFFFF_FFFF, 32'd0,         32'hFFFF_FFFF, 1'b1, 32'd1},
        '{32'd0,         32'd0,         32'd0,         1'b1, 32'd0},
        '{32'd0,         32'd0,         32'd1,         1'b1, 32'd0},
        '{32'd0,         32'd5,         32'd97,        1'b1, 32'd0},
        '{32'd3,         32'd1,         32'd100,       1'b1, 32'd3},
        '{32'd2,         32'd10,        32'd100000,    1'b1, 32'd1024},
        '{32'd2,         32'd31,        32'hFFFF_FFFF, 1'b1, 32'h8000_0000},
        '{32'hFFFF_FFFF, 32'd1,         32'hFFFF_FFFF, 1'b1, 32'd0},
        '{32'hFFFF_FFFE, 32'd2,         32'hFFFF_FFFF, 1'b1, 32'd1},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, 32'd1},
        '{32'd1,         32'hFFFF_FFFF, 32'd12345,     1'b1, 32'd1},
        '{32'd3,         32'hFFFF_FFFF, 32'hFFFF_FFFB, 1'b0, 32'd0},
        '{32'hDEAD_BEEF, 32'h8000_0000, 32'hFFFF_FFF1, 1'b0, 32'd0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0},
        '{32'd10,        32'd7,         32'd2,         1'b1, 32'd0},
        '{32'd9,         32'd3,         32'd3,         1'b1, 32'd0},
        '{32'd7,         32'd2,         32'd13,        1'b1, 32'd10},
        '{32'h1234_5678, 32'h5555_5555, 32'h8000_0000, 1'b0, 32'd0},
        '{32'hABCD_EF01, 32'h0001_0001, 32'h7FFF_FFFF, 1'b0, 32'd0},
        '{32'd5,         32'd2,         32'd2,         1'b1, 32'd1}
    };

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   mismatches;
    int   ready_hold;

    mexp_pkg::data_t expected_power_q [$];

    mexp_in_if  operands_ch ();
    mexp_out_if result_ch ();

    modular_exponentiation_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operands_ch),
        .result   (result_ch)
    );

    // Clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Predict base ** exponent mod modulus, right-to-left square-and-multiply
    function automatic mexp_pkg::data_t modpow_expect(input mexp_pkg::data_t b_in,
                                                      input mexp_pkg::data_t e_in,
                                                      input mexp_pkg::data_t m_in);
        logic [63:0] b;
        logic [63:0] e;
        logic [63:0] m;
        logic [63:0] acc;
        b   = 64'(b_in);
        e   = 64'(e_in) & EXP_MASK;
        m   = 64'(m_in) & MOD_MASK;
        acc = 64'd1;
        if (m <= 64'd1)
            return '0;
        if (e == 64'd0)
            return mexp_pkg::data_t'(1);
        b = b % m;
        while (e != 64'd0)
        begin
            if (e[0])
                acc = (acc * b) % m;
            b = (b * b) % m;
            e = e >> 1;
        end
        return acc[mexp_pkg::DATA_WIDTH-1:0];
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 45)
            return 0;
        if (r < 85)
            return int'($urandom_range(1, 4));
        if (r < 95)
            return int'($urandom_range(5, 30));
        return int'($urandom_range(100, 600));
    endfunction

    // Offer one operand word, hold it until taken, then log its expected power
    task automatic send_word(input mexp_pkg::data_t b, input mexp_pkg::data_t e,
                             input mexp_pkg::data_t m, input logic known,
                             input mexp_pkg::data_t known_power);
        int              gap;
        mexp_pkg::data_t want;
        gap = pick_gap();
        if (gap > 0)
        begin
            operands_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operands_ch.valid    <= 1'b1;
        operands_ch.base     <= b;
        operands_ch.exponent <= e;
        operands_ch.modulus  <= m;
        @(posedge clk);
        while (!operands_ch.ready)
            @(posedge clk);
        want             = known ? known_power : modpow_expect(b, e, m);
        expected_power_q = {expected_power_q, want};
    endtask

    // Reset, directed table, random words, drain
    initial
    begin
        mexp_pkg::data_t rb;
        mexp_pkg::data_t re;
        mexp_pkg::data_t rm;
        int              r;
        int              n;
        rst_n                = 1'b0;
        mismatches           = 0;
        operands_ch.valid    = 1'b0;
        operands_ch.base     = '0;
        operands_ch.exponent = '0;
        operands_ch.modulus  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int idx = 0; idx < DIR_ROWS; idx++)
            send_word(DIR_TABLE[idx].base, DIR_TABLE[idx].exponent, DIR_TABLE[idx].modulus,
                      DIR_TABLE[idx].known, DIR_TABLE[idx].power);

        for (int idx = 0; idx < RANDOM_ITEMS; idx++)
        begin
            // modulus: trivial, small, near the top, or full range
            r = int'($urandom_range(0, 99));
            if (r < 4)
                rm = mexp_pkg::data_t'($urandom_range(0, 1));
            else if (r < 14)
                rm = mexp_pkg::data_t'($urandom_range(2, 255));
            else if (r < 20)
                rm = 32'hFFFF_FFFF - mexp_pkg::data_t'($urandom_range(0, 15));
            else
                rm = $urandom;

            // exponent: zero, short, all ones, or full range
            r = int'($urandom_range(0, 99));
            if (r < 5)
                re = '0;
            else if (r < 45)
            begin
                n  = int'($urandom_range(1, 8));
                re = $urandom & ((32'd1 << n) - 32'd1);
            end
            else if (r < 50)
                re = 32'hFFFF_FFFF;
            else
                re = $urandom;

            // base: zero, all ones, equal to modulus, tiny, or full range
            r = int'($urandom_range(0, 99));
            if (r < 5)
                rb = '0;
            else if (r < 10)
                rb = 32'hFFFF_FFFF;
            else if (r < 15)
                rb = rm;
            else if (r < 20)
                rb = mexp_pkg::data_t'($urandom_range(0, 3));
            else
                rb = $urandom;

            send_word(rb, re, rm, 1'b0, '0);
        end
        operands_ch.valid <= 1'b0;

        while (expected_power_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("modular_exponentiation_unit: match");
        else
            $display("modular_exponentiation_unit: mismatch");
        $finish;
    end

    // Result side: stall at random, with long stretches of steady ready
    initial
    begin
        result_ch.ready = 1'b0;
        ready_hold      = 0;
    end

    always @(posedge clk)
    begin
        int r;
        if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            r = int'($urandom_range(0, 99));
            if (r < 10)
            begin
                result_ch.ready <= 1'b1;
                ready_hold      <= int'($urandom_range(500, 3000));
            end
            else if (r < 60)
            begin
                result_ch.ready <= 1'b1;
                ready_hold      <= int'($urandom_range(1, 60));
            end
            else if (r < 90)
            begin
                result_ch.ready <= 1'b0;
                ready_hold      <= int'($urandom_range(1, 4));
            end
            else
            begin
                result_ch.ready <= 1'b0;
                ready_hold      <= int'($urandom_range(50, 800));
            end
        end
    end

    // Compare each taken result word with the oldest expected power
    always @(posedge clk)
    begin
        mexp_pkg::data_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_power_q.size() == 0)
            begin
                $error("unexpected result word: power actual %0h", result_ch.power);
                mismatches++;
            end
            else
            begin
                want = expected_power_q.pop_front();
                if (result_ch.power !== want)
                begin
                    $error("power: expected %0h, actual %0h", want, result_ch.power);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    initial cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("modular_exponentiation_unit: mismatch");
            $finish;
        end
    end

endmodule
